### hdl/lhm_pkg.sv
// Shared types, constants and helper functions for the link health monitor.
`timescale 1ns / 1ps

package lhm_pkg;

    // Counter and accumulator widths
    localparam int FIELD_BITS   = 32;
    localparam int COUNTER_BITS = 32;
    localparam int TOTAL_BITS   = 48;
    localparam int TICK_BITS    = 8;
    localparam int BUCKET_BITS  = 3;
    localparam int BAND_BITS    = 2;
    localparam int N_COUNTERS   = 6;
    localparam int ADD_BITS     =
        ((COUNTER_BITS > TOTAL_BITS) ? COUNTER_BITS : TOTAL_BITS) + 1;

    // Configuration register layout
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_ADDR_BITS  = 4;
    localparam int SUSTAIN_BITS   = 8;
    localparam int INTERVAL_BITS  = 16;
    localparam int MIN_SAMP_BITS  = 16;
    localparam int RATE_BITS      = 7;

    localparam logic [SUSTAIN_BITS-1:0]  SUSTAIN_RESET  = SUSTAIN_BITS'(3);
    localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = INTERVAL_BITS'(500);
    localparam logic [MIN_SAMP_BITS-1:0] MIN_SAMP_RESET = MIN_SAMP_BITS'(20);
    localparam logic [RATE_BITS-1:0]     RATE_RESET     = RATE_BITS'(5);
    localparam logic [RATE_BITS-1:0]     RATE_FULL      = RATE_BITS'(100);

    typedef enum logic [1:0] {
        CFG_SUSTAIN     = 2'd0,
        CFG_INTERVAL    = 2'd1,
        CFG_MIN_SAMPLES = 2'd2,
        CFG_WARN_RATE   = 2'd3
    } t_cfg_reg;

    // Counter slots, in snapshot order
    localparam int CNT_BYTES   = 0;
    localparam int CNT_FRAMES  = 1;
    localparam int CNT_CRC     = 2;
    localparam int CNT_DROP    = 3;
    localparam int CNT_OVFL    = 4;
    localparam int CNT_PARSED  = 5;

    // Checksum rate bands
    localparam logic [BAND_BITS-1:0] BAND_LOW  = BAND_BITS'(0);
    localparam logic [BAND_BITS-1:0] BAND_MID  = BAND_BITS'(1);
    localparam logic [BAND_BITS-1:0] BAND_HIGH = BAND_BITS'(2);

    typedef logic [FIELD_BITS-1:0]   t_field;
    typedef logic [COUNTER_BITS-1:0] t_counter;
    typedef logic [TOTAL_BITS-1:0]   t_total;
    typedef logic [TICK_BITS-1:0]    t_ticks;
    typedef logic [BUCKET_BITS-1:0]  t_bucket;

    localparam t_total TOTAL_MAX = '1;

    typedef struct packed {
        logic   suppressed;
        t_field time_ms;
        t_field bytes_received;
        t_field frames_found;
        t_field crc_failures;
        t_field frames_lost;
        t_field bytes_lost;
        t_field frames_parsed;
    } t_snapshot;

    typedef struct packed {
        logic                 no_frames_alarm;
        logic                 no_parse_alarm;
        logic                 checksum_warning;
        logic                 dropped_warning;
        logic                 overflow_warning;
        t_bucket              window_bytes_bucket;
        t_bucket              window_frames_bucket;
        logic [BAND_BITS-1:0] checksum_band;
        t_bucket              dropped_bucket;
        t_bucket              overflow_bucket;
    } t_report;

    typedef struct packed {
        t_ticks stall_frame_ticks;
        t_ticks stall_parse_ticks;
        t_total stall_window_bytes;
        t_total stall_window_frames;
        t_total sum_frames;
        t_total sum_dropped;
        t_total sum_crc_failures;
        t_total sum_overflow;
    } t_windows;

    typedef struct packed {
        logic [SUSTAIN_BITS-1:0]  sustain_ticks;
        logic [INTERVAL_BITS-1:0] min_sample_interval_ms;
        logic [MIN_SAMP_BITS-1:0] min_checksum_samples;
        logic [RATE_BITS-1:0]     warn_rate_percent;
    } t_cfg;

    function automatic t_total sat_add(input t_total a, input t_counter b);
        logic [ADD_BITS-1:0] s;
        s = ADD_BITS'(a) + ADD_BITS'(b);
        if (s > ADD_BITS'(TOTAL_MAX)) begin
            return TOTAL_MAX;
        end
        return TOTAL_BITS'(s);
    endfunction

    function automatic t_ticks tick_up(input t_ticks t);
        if (t == '1) begin
            return t;
        end
        return TICK_BITS'(t + 1'b1);
    endfunction

    function automatic t_bucket decade(input t_total v);
        if (v >= TOTAL_BITS'(1000000)) return BUCKET_BITS'(6);
        if (v >= TOTAL_BITS'(100000))  return BUCKET_BITS'(5);
        if (v >= TOTAL_BITS'(10000))   return BUCKET_BITS'(4);
        if (v >= TOTAL_BITS'(1000))    return BUCKET_BITS'(3);
        if (v >= TOTAL_BITS'(100))     return BUCKET_BITS'(2);
        if (v >= TOTAL_BITS'(10))      return BUCKET_BITS'(1);
        return BUCKET_BITS'(0);
    endfunction

endpackage

### hdl/lhm_if.sv
// Valid/ready channel interfaces for snapshots and reports.
`timescale 1ns / 1ps

interface lhm_snap_if import lhm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_snapshot payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lhm_report_if import lhm_pkg::*; ();
    logic    valid;
    logic    ready;
    t_report payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hdl/lhm_fold.sv
// Baseline, interval gate and window/total accumulation state.
`timescale 1ns / 1ps

module lhm_fold import lhm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  t_snapshot                i_snap,
    input  logic [INTERVAL_BITS-1:0] i_min_interval,
    output t_windows                 o_win
);

    logic     r_baseline, n_baseline;
    t_field   r_last_time, n_last_time;
    t_counter r_prev [N_COUNTERS];
    t_counter n_prev [N_COUNTERS];
    t_windows r_win, n_win;

    t_counter cur   [N_COUNTERS];
    t_counter delta [N_COUNTERS];
    t_field   gap;
    logic     too_soon;
    logic     went_down;

    always_comb begin
        cur[CNT_BYTES]  = COUNTER_BITS'(i_snap.bytes_received);
        cur[CNT_FRAMES] = COUNTER_BITS'(i_snap.frames_found);
        cur[CNT_CRC]    = COUNTER_BITS'(i_snap.crc_failures);
        cur[CNT_DROP]   = COUNTER_BITS'(i_snap.frames_lost);
        cur[CNT_OVFL]   = COUNTER_BITS'(i_snap.bytes_lost);
        cur[CNT_PARSED] = COUNTER_BITS'(i_snap.frames_parsed);

        went_down = 1'b0;
        for (int k = 0; k < N_COUNTERS; k++) begin
            delta[k]  = cur[k] - r_prev[k];
            went_down = went_down | (cur[k] < r_prev[k]);
        end

        gap      = i_snap.time_ms - r_last_time;
        too_soon = r_baseline && (gap < FIELD_BITS'(i_min_interval));
    end

    always_comb begin
        n_baseline  = r_baseline;
        n_last_time = r_last_time;
        n_win       = r_win;
        for (int k = 0; k < N_COUNTERS; k++) begin
            n_prev[k] = r_prev[k];
        end

        if (i_accept) begin
            if (i_snap.suppressed) begin
                n_baseline  = 1'b0;
                n_last_time = '0;
                n_win       = '0;
                for (int k = 0; k < N_COUNTERS; k++) begin
                    n_prev[k] = '0;
                end
            end else if (!too_soon) begin
                if (!r_baseline || went_down) begin
                    n_win = '0;
                end else begin
                    n_win.sum_frames       = sat_add(r_win.sum_frames, delta[CNT_FRAMES]);
                    n_win.sum_crc_failures = sat_add(r_win.sum_crc_failures, delta[CNT_CRC]);
                    n_win.sum_dropped      = sat_add(r_win.sum_dropped, delta[CNT_DROP]);
                    n_win.sum_overflow     = sat_add(r_win.sum_overflow, delta[CNT_OVFL]);

                    // bytes flowing but no frames coming out
                    if (delta[CNT_BYTES] != '0 && delta[CNT_FRAMES] == '0) begin
                        n_win.stall_frame_ticks  = tick_up(r_win.stall_frame_ticks);
                        n_win.stall_window_bytes =
                            sat_add(r_win.stall_window_bytes, delta[CNT_BYTES]);
                    end else begin
                        n_win.stall_frame_ticks  = '0;
                        n_win.stall_window_bytes = '0;
                    end

                    // frames found but none parsed
                    if (delta[CNT_FRAMES] != '0 && delta[CNT_PARSED] == '0) begin
                        n_win.stall_parse_ticks   = tick_up(r_win.stall_parse_ticks);
                        n_win.stall_window_frames =
                            sat_add(r_win.stall_window_frames, delta[CNT_FRAMES]);
                    end else begin
                        n_win.stall_parse_ticks   = '0;
                        n_win.stall_window_frames = '0;
                    end
                end
                n_last_time = i_snap.time_ms;
                n_baseline  = 1'b1;
                for (int k = 0; k < N_COUNTERS; k++) begin
                    n_prev[k] = cur[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline  <= 1'b0;
            r_last_time <= '0;
            r_win       <= '0;
            for (int k = 0; k < N_COUNTERS; k++) begin
                r_prev[k] <= '0;
            end
        end else begin
            r_baseline  <= n_baseline;
            r_last_time <= n_last_time;
            r_win       <= n_win;
            for (int k = 0; k < N_COUNTERS; k++) begin
                r_prev[k] <= n_prev[k];
            end
        end
    end

    assign o_win = r_win;

endmodule

### hdl/lhm_judge.sv
// Alarm, warning, bucket and checksum band evaluation of the window state.
`timescale 1ns / 1ps

module lhm_judge import lhm_pkg::*; (
    input  t_windows i_win,
    input  t_cfg     i_cfg,
    output t_report  o_report
);

    localparam int PROD_BITS = TOTAL_BITS + RATE_BITS;
    localparam int SUM_BITS  = TOTAL_BITS + 1;
    localparam int QUAD_BITS = TOTAL_BITS + 2;

    logic [SUSTAIN_BITS-1:0] need;
    logic [RATE_BITS-1:0]    rate_rest;
    logic [PROD_BITS-1:0]    prod_err;
    logic [PROD_BITS-1:0]    prod_frm;
    logic [SUM_BITS-1:0]     total;
    logic                    judged;
    logic                    warn;
    logic [BAND_BITS-1:0]    band;
    t_total                  err;
    t_total                  frm;

    always_comb begin
        err  = i_win.sum_crc_failures;
        frm  = i_win.sum_frames;
        need = (i_cfg.sustain_ticks == '0) ? SUSTAIN_BITS'(1) : i_cfg.sustain_ticks;

        // 100*err >= w*(err+frm) rewritten as (100-w)*err >= w*frm
        rate_rest = RATE_FULL - i_cfg.warn_rate_percent;
        prod_err  = PROD_BITS'(err) * PROD_BITS'(rate_rest);
        prod_frm  = PROD_BITS'(frm) * PROD_BITS'(i_cfg.warn_rate_percent);
        total     = SUM_BITS'(err) + SUM_BITS'(frm);

        judged = (total >= SUM_BITS'(i_cfg.min_checksum_samples))
              && (err != '0)
              && (i_cfg.warn_rate_percent <= RATE_FULL);
        warn   = judged && (prod_err >= prod_frm);

        band = BAND_LOW;
        if (warn) begin
            if (err >= frm) begin
                band = BAND_HIGH;
            end else if ((QUAD_BITS'(err) << 2) >= QUAD_BITS'(frm)) begin
                band = BAND_MID;
            end
        end

        o_report.no_frames_alarm      = (i_win.stall_frame_ticks >= TICK_BITS'(need));
        o_report.no_parse_alarm       = (i_win.stall_parse_ticks >= TICK_BITS'(need));
        o_report.checksum_warning     = warn;
        o_report.dropped_warning      = (i_win.sum_dropped != '0);
        o_report.overflow_warning     = (i_win.sum_overflow != '0);
        o_report.window_bytes_bucket  = decade(i_win.stall_window_bytes);
        o_report.window_frames_bucket = decade(i_win.stall_window_frames);
        o_report.checksum_band        = band;
        o_report.dropped_bucket       = decade(i_win.sum_dropped);
        o_report.overflow_bucket      = decade(i_win.sum_overflow);
    end

endmodule

### hdl/link_health_monitor.sv
// Top level of the link health monitor: config registers, fold stage, report stage.
`timescale 1ns / 1ps

// Link health monitor. Each snapshot transfer on i_snap carries six cumulative
// link counters, a millisecond timestamp and a suppress flag; every snapshot
// produces exactly one report transfer on o_report, in order. The block takes
// one snapshot per clock while i_snap.ready is high: the accepting edge updates
// the baseline, windows and saturating totals, and the first edge at which the
// report register is free loads it from that state. A snapshot's effect thus
// passes the window state and the stage 1 flag, then the report register,
// and the throughput is one item per cycle for as long as o_report.ready stays
// high. The report register decouples the two sides; i_snap.ready drops only
// when a finished report and the one behind it are both waiting. The four
// settings sit on an APB-style port at byte addresses 0, 4, 8 and 12 (sustain
// ticks, minimum sample interval, minimum checksum samples, warning percent);
// change them only while no snapshot is in flight. Valid flags, window state and
// settings reset, no sweep needed; the report payload register has no reset.
module link_health_monitor import lhm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    lhm_snap_if.sink                 i_snap,
    lhm_report_if.source             o_report,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    t_cfg     r_cfg, n_cfg;
    t_cfg_reg cfg_sel;
    logic     cfg_wr;

    logic     snap_xfer;
    logic     r_s1_valid, n_s1_valid;
    logic     s1_move;
    logic     r_out_valid, n_out_valid;
    t_report  r_out;
    t_report  judged;
    t_windows win;

    // ---------------------------------------------------------------
    // Configuration port: write on the access cycle, read combinational
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_sel = t_cfg_reg'(paddr[CFG_ADDR_BITS-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            unique case (cfg_sel)
                CFG_SUSTAIN:     n_cfg.sustain_ticks          = pwdata[SUSTAIN_BITS-1:0];
                CFG_INTERVAL:    n_cfg.min_sample_interval_ms = pwdata[INTERVAL_BITS-1:0];
                CFG_MIN_SAMPLES: n_cfg.min_checksum_samples   = pwdata[MIN_SAMP_BITS-1:0];
                CFG_WARN_RATE:   n_cfg.warn_rate_percent      = pwdata[RATE_BITS-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            CFG_SUSTAIN:     prdata = CFG_DATA_BITS'(r_cfg.sustain_ticks);
            CFG_INTERVAL:    prdata = CFG_DATA_BITS'(r_cfg.min_sample_interval_ms);
            CFG_MIN_SAMPLES: prdata = CFG_DATA_BITS'(r_cfg.min_checksum_samples);
            CFG_WARN_RATE:   prdata = CFG_DATA_BITS'(r_cfg.warn_rate_percent);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sustain_ticks          <= SUSTAIN_RESET;
            r_cfg.min_sample_interval_ms <= INTERVAL_RESET;
            r_cfg.min_checksum_samples   <= MIN_SAMP_RESET;
            r_cfg.warn_rate_percent      <= RATE_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // ---------------------------------------------------------------
    // Flow control
    // Stage 1 marks that the window state holds a not-yet-reported
    // update. It advances into the report register whenever that
    // register is empty or being drained this cycle. Hold the input
    // while stage 1 is stuck so the state it reports stays put.
    // ---------------------------------------------------------------
    assign s1_move        = r_s1_valid && (!r_out_valid || o_report.ready);
    assign i_snap.ready   = !r_s1_valid || s1_move;
    assign snap_xfer      = i_snap.valid && i_snap.ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (snap_xfer) begin
            n_s1_valid = 1'b1;
        end else if (s1_move) begin
            n_s1_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (s1_move) begin
            n_out_valid = 1'b1;
        end else if (o_report.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // ---------------------------------------------------------------
    // Datapath: fold the snapshot into state, then judge the state
    // ---------------------------------------------------------------
    lhm_fold u_fold (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (snap_xfer),
        .i_snap         (i_snap.payload),
        .i_min_interval (r_cfg.min_sample_interval_ms),
        .o_win          (win)
    );

    lhm_judge u_judge (
        .i_win    (win),
        .i_cfg    (r_cfg),
        .o_report (judged)
    );

    // Load the report only when stage 1 advances; hold it otherwise.
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out <= judged;
        end
    end

    assign o_report.valid   = r_out_valid;
    assign o_report.payload = r_out;

endmodule

### hdl/lhm_checker.sv
// Port-level assertions for the link health monitor and their bind.
`timescale 1ns / 1ps

module lhm_checker import lhm_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    i_in_ready,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input t_report i_out_payload
);

    logic       in_xfer;
    logic       out_xfer;
    logic [1:0] r_pending, n_pending;

    assign in_xfer  = i_in_valid && i_in_ready;
    assign out_xfer = i_out_valid && i_out_ready;

    always_comb begin
        n_pending = r_pending + 2'(in_xfer) - 2'(out_xfer);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    // At most two snapshots are in flight: one in state, one in the report register.
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 2'd2)
        else $error("more than two snapshots in flight");

    // Never deliver a report that no snapshot asked for.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |-> (r_pending != 2'd0))
        else $error("report delivered with no snapshot outstanding");

    // Hold off the input only while a finished report is stalled.
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input stalled with no stalled report");

    // A stalled report stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_payload)))
        else $error("stalled report dropped or changed");

endmodule

bind link_health_monitor lhm_checker u_lhm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_snap.valid),
    .i_in_ready    (i_snap.ready),
    .i_out_valid   (o_report.valid),
    .i_out_ready   (o_report.ready),
    .i_out_payload (o_report.payload)
);

### verif/tb_link_health_monitor.sv
// Self-checking testbench for the link health monitor: directed, extreme and random snapshots.
`timescale 1ns / 1ps

module tb_link_health_monitor;
    import lhm_pkg::*;

    localparam int REG_STRIDE     = 4;     // byte distance between registers
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer or register access before giving up
    localparam int SETTLE_CYCLES  = 8;     // extra wait after the last expected report
    localparam int LONG_HOLD      = 300;   // receiver hold-off while the sender keeps pushing
    localparam int PRINT_CAP      = 60;

    logic                     i_clk   = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr   = '0;
    logic [CFG_DATA_BITS-1:0] pwdata  = '0;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    lhm_snap_if   snap_ch ();
    lhm_report_if report_ch ();

    link_health_monitor DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_snap   (snap_ch),
        .o_report (report_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Health predictor: own copy of the settings and the monitor state
    // ------------------------------------------------------------------
    t_cfg     cfg;
    logic     base_ok;
    t_field   last_time;
    t_counter prev_cnt [N_COUNTERS];
    t_ticks   frame_ticks, parse_ticks;
    t_total   win_bytes, win_frames;
    t_total   tot_frames, tot_dropped, tot_crc, tot_ovfl;

    t_report  expected_reports [$];

    int unsigned mismatches   = 0;
    int unsigned n_snaps      = 0;
    int unsigned n_reports    = 0;
    int unsigned n_settings   = 0;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_idle_pct  = 0;
    int unsigned hold_left    = 0;
    int unsigned quiet_cycles = 0;

    // Link counters the random sequences grow
    t_field   link_time;
    t_counter link_cnt [N_COUNTERS];

    function automatic t_total add_sat(t_total acc, t_counter delta);
        logic [TOTAL_BITS:0] s;
        s = {1'b0, acc} + (TOTAL_BITS + 1)'(delta);
        return s[TOTAL_BITS] ? TOTAL_MAX : s[TOTAL_BITS-1:0];
    endfunction

    function automatic t_bucket decade_of(t_total v);
        t_bucket         b   = '0;
        longint unsigned lim = 10;
        while (b < 6 && 64'(v) >= lim) begin
            b++;
            lim = lim * 10;
        end
        return b;
    endfunction

    function automatic void clear_windows();
        frame_ticks = '0;
        parse_ticks = '0;
        win_bytes   = '0;
        win_frames  = '0;
        tot_frames  = '0;
        tot_dropped = '0;
        tot_crc     = '0;
        tot_ovfl    = '0;
    endfunction

    function automatic void clear_all();
        clear_windows();
        base_ok   = 1'b0;
        last_time = '0;
        foreach (prev_cnt[i]) prev_cnt[i] = '0;
    endfunction

    // Advance the state by one snapshot and return the report it should produce.
    function automatic t_report predict_report(t_snapshot s);
        t_counter    cur [N_COUNTERS];
        t_counter    d_bytes, d_frames, d_parsed;
        t_field      gap;
        t_ticks      need;
        logic        went_down;
        logic [63:0] total, lhs, rhs;
        t_report     r;

        cur[CNT_BYTES]  = s.bytes_received;
        cur[CNT_FRAMES] = s.frames_found;
        cur[CNT_CRC]    = s.crc_failures;
        cur[CNT_DROP]   = s.frames_lost;
        cur[CNT_OVFL]   = s.bytes_lost;
        cur[CNT_PARSED] = s.frames_parsed;
        gap = s.time_ms - last_time;

        if (s.suppressed) begin
            clear_all();
        end else if (!(base_ok && gap < FIELD_BITS'(cfg.min_sample_interval_ms))) begin
            went_down = 1'b0;
            foreach (cur[i]) begin
                if (cur[i] < prev_cnt[i]) went_down = 1'b1;
            end
            if (!base_ok || went_down) begin
                clear_windows();
            end else begin
                d_bytes  = cur[CNT_BYTES]  - prev_cnt[CNT_BYTES];
                d_frames = cur[CNT_FRAMES] - prev_cnt[CNT_FRAMES];
                d_parsed = cur[CNT_PARSED] - prev_cnt[CNT_PARSED];
                tot_frames  = add_sat(tot_frames, d_frames);
                tot_crc     = add_sat(tot_crc, cur[CNT_CRC] - prev_cnt[CNT_CRC]);
                tot_dropped = add_sat(tot_dropped, cur[CNT_DROP] - prev_cnt[CNT_DROP]);
                tot_ovfl    = add_sat(tot_ovfl, cur[CNT_OVFL] - prev_cnt[CNT_OVFL]);
                // bytes with no frames
                if (d_bytes != 0 && d_frames == 0) begin
                    if (frame_ticks != '1) frame_ticks++;
                    win_bytes = add_sat(win_bytes, d_bytes);
                end else begin
                    frame_ticks = '0;
                    win_bytes   = '0;
                end
                // frames with no parses
                if (d_frames != 0 && d_parsed == 0) begin
                    if (parse_ticks != '1) parse_ticks++;
                    win_frames = add_sat(win_frames, d_frames);
                end else begin
                    parse_ticks = '0;
                    win_frames  = '0;
                end
            end
            last_time = s.time_ms;
            base_ok   = 1'b1;
            prev_cnt  = cur;
        end

        need = (cfg.sustain_ticks == 0) ? t_ticks'(1) : t_ticks'(cfg.sustain_ticks);
        r = '0;
        r.no_frames_alarm      = frame_ticks >= need;
        r.no_parse_alarm       = parse_ticks >= need;
        r.dropped_warning      = tot_dropped != 0;
        r.overflow_warning     = tot_ovfl != 0;
        r.window_bytes_bucket  = decade_of(win_bytes);
        r.window_frames_bucket = decade_of(win_frames);
        r.dropped_bucket       = decade_of(tot_dropped);
        r.overflow_bucket      = decade_of(tot_ovfl);
        r.checksum_band        = BAND_LOW;

        // failure rate judged only with enough samples; compare on integers
        total = 64'(tot_crc) + 64'(tot_frames);
        if (total >= 64'(cfg.min_checksum_samples) && tot_crc != 0 &&
            cfg.warn_rate_percent <= RATE_FULL) begin
            lhs = 64'(tot_crc) * (64'(RATE_FULL) - 64'(cfg.warn_rate_percent));
            rhs = 64'(tot_frames) * 64'(cfg.warn_rate_percent);
            if (lhs >= rhs) begin
                r.checksum_warning = 1'b1;
                if (tot_crc >= tot_frames) begin
                    r.checksum_band = BAND_HIGH;
                end else if (64'(tot_crc) * 4 >= 64'(tot_frames)) begin
                    r.checksum_band = BAND_MID;
                end
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting and report checking
    // ------------------------------------------------------------------
    function automatic void flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
    endfunction

    function automatic void compare_field(string name, int unsigned got, int unsigned want);
        if (got != want) begin
            flag_mismatch($sformatf("report %0d %s got %0d want %0d",
                                    n_reports, name, got, want));
        end
    endfunction

    t_report got_r, want_r;

    // Check the report transfer first, then predict the snapshot transfer of the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n && report_ch.valid && report_ch.ready) begin
            got_r = report_ch.payload;
            if (expected_reports.size() == 0) begin
                flag_mismatch("report with no snapshot pending");
            end else begin
                want_r = expected_reports.pop_front();
                compare_field("no_frames_alarm", got_r.no_frames_alarm, want_r.no_frames_alarm);
                compare_field("no_parse_alarm", got_r.no_parse_alarm, want_r.no_parse_alarm);
                compare_field("checksum_warning", got_r.checksum_warning,
                              want_r.checksum_warning);
                compare_field("dropped_warning", got_r.dropped_warning, want_r.dropped_warning);
                compare_field("overflow_warning", got_r.overflow_warning,
                              want_r.overflow_warning);
                compare_field("window_bytes_bucket", got_r.window_bytes_bucket,
                              want_r.window_bytes_bucket);
                compare_field("window_frames_bucket", got_r.window_frames_bucket,
                              want_r.window_frames_bucket);
                compare_field("checksum_band", got_r.checksum_band, want_r.checksum_band);
                compare_field("dropped_bucket", got_r.dropped_bucket, want_r.dropped_bucket);
                compare_field("overflow_bucket", got_r.overflow_bucket, want_r.overflow_bucket);
            end
            n_reports++;
        end
        if (i_rst_n && snap_ch.valid && snap_ch.ready) begin
            expected_reports.push_back(predict_report(snap_ch.payload));
            n_snaps++;
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((snap_ch.valid && snap_ch.ready) || (report_ch.valid && report_ch.ready) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL link_health_monitor");
            $finish;
        end
    end

    // Receiver: long hold-off when asked, else random stalls.
    initial begin
        report_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                report_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                report_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Offer one snapshot, hold it until the transfer, then maybe idle.
    task automatic send_snap(t_snapshot s);
        snap_ch.valid   <= 1'b1;
        snap_ch.payload <= s;
        do @(posedge i_clk); while (!snap_ch.ready);
        while ($urandom_range(99) < tx_idle_pct) begin
            snap_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every report has come back.
    task automatic drain_reports();
        snap_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_link(logic supp);
        t_snapshot s;
        s.suppressed     = supp;
        s.time_ms        = link_time;
        s.bytes_received = link_cnt[CNT_BYTES];
        s.frames_found   = link_cnt[CNT_FRAMES];
        s.crc_failures   = link_cnt[CNT_CRC];
        s.frames_lost    = link_cnt[CNT_DROP];
        s.bytes_lost     = link_cnt[CNT_OVFL];
        s.frames_parsed  = link_cnt[CNT_PARSED];
        send_snap(s);
    endtask

    task automatic set_link(t_field t, t_counter c);
        link_time = t;
        foreach (link_cnt[i]) link_cnt[i] = c;
    endtask

    // Advance time and grow the counters by the given deltas, then send.
    task automatic bump(int unsigned dt, t_counter d_bytes, t_counter d_frames,
                        t_counter d_crc, t_counter d_drop, t_counter d_ovfl,
                        t_counter d_parsed);
        link_time            += dt;
        link_cnt[CNT_BYTES]  += d_bytes;
        link_cnt[CNT_FRAMES] += d_frames;
        link_cnt[CNT_CRC]    += d_crc;
        link_cnt[CNT_DROP]   += d_drop;
        link_cnt[CNT_OVFL]   += d_ovfl;
        link_cnt[CNT_PARSED] += d_parsed;
        send_link(1'b0);
    endtask

    // Delta spread over all decades, up to two million.
    function automatic t_counter spread();
        int unsigned span = 1;
        repeat ($urandom_range(0, 6)) span = span * 10;
        return t_counter'($urandom_range(1, 2 * span));
    endfunction

    // Mostly well-formed growth of the link; some noise, suppresses and resets.
    task automatic random_step();
        int unsigned pick;
        t_counter    d_frames;
        t_snapshot   noise;
        pick = $urandom_range(99);
        if (pick < 4) begin
            noise.suppressed     = 1'($urandom_range(1));
            noise.time_ms        = $urandom;
            noise.bytes_received = $urandom;
            noise.frames_found   = $urandom;
            noise.crc_failures   = $urandom;
            noise.frames_lost    = $urandom;
            noise.bytes_lost     = $urandom;
            noise.frames_parsed  = $urandom;
            send_snap(noise);
        end else if (pick < 7) begin
            send_link(1'b1);
        end else begin
            if (pick < 10) begin
                link_cnt[$urandom_range(N_COUNTERS - 1)] -= spread();
            end else if (pick < 12) begin
                link_time = $urandom;
                foreach (link_cnt[i]) link_cnt[i] = $urandom;
            end
            if ($urandom_range(99) < 15) begin
                link_time += $urandom_range(0, cfg.min_sample_interval_ms);
            end else begin
                link_time += cfg.min_sample_interval_ms + $urandom_range(0, 2000);
            end
            d_frames = ($urandom_range(99) < 40) ? '0 : spread();
            link_cnt[CNT_BYTES]  += ($urandom_range(99) < 15) ? '0 : spread();
            link_cnt[CNT_FRAMES] += d_frames;
            link_cnt[CNT_PARSED] += ($urandom_range(99) < 40) ? '0 : d_frames;
            link_cnt[CNT_CRC]    += ($urandom_range(99) < 50) ? '0 :
                                    t_counter'($urandom_range(0, d_frames + 10));
            link_cnt[CNT_DROP]   += ($urandom_range(99) < 80) ? '0 : spread();
            link_cnt[CNT_OVFL]   += ($urandom_range(99) < 80) ? '0 : spread();
            send_link(1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    function automatic logic [CFG_DATA_BITS-1:0] reg_value(t_cfg_reg idx);
        case (idx)
            CFG_SUSTAIN:     return CFG_DATA_BITS'(cfg.sustain_ticks);
            CFG_INTERVAL:    return CFG_DATA_BITS'(cfg.min_sample_interval_ms);
            CFG_MIN_SAMPLES: return CFG_DATA_BITS'(cfg.min_checksum_samples);
            default:         return CFG_DATA_BITS'(cfg.warn_rate_percent);
        endcase
    endfunction

    // Setup cycle, access cycle, then one idle cycle so psel never toggles twice in a step.
    task automatic apb_access(logic is_write, t_cfg_reg idx, logic [CFG_DATA_BITS-1:0] data,
                              output logic [CFG_DATA_BITS-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= CFG_ADDR_BITS'(REG_STRIDE * int'(idx));
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_reg(t_cfg_reg idx);
        logic [CFG_DATA_BITS-1:0] rd;
        apb_access(1'b0, idx, '0, rd);
        if (rd !== reg_value(idx)) begin
            flag_mismatch($sformatf("register %s read %0h want %0h", idx.name(), rd,
                                    reg_value(idx)));
        end
    endtask

    task automatic write_reg(t_cfg_reg idx, int unsigned value);
        logic [CFG_DATA_BITS-1:0] rd;
        apb_access(1'b1, idx, CFG_DATA_BITS'(value), rd);
        case (idx)
            CFG_SUSTAIN:     cfg.sustain_ticks          = SUSTAIN_BITS'(value);
            CFG_INTERVAL:    cfg.min_sample_interval_ms = INTERVAL_BITS'(value);
            CFG_MIN_SAMPLES: cfg.min_checksum_samples   = MIN_SAMP_BITS'(value);
            default:         cfg.warn_rate_percent      = RATE_BITS'(value);
        endcase
        check_reg(idx);
    endtask

    // Change settings only with nothing in flight.
    task automatic set_config(int unsigned sustain, int unsigned interval,
                              int unsigned min_samp, int unsigned rate);
        drain_reports();
        write_reg(CFG_SUSTAIN, sustain);
        write_reg(CFG_INTERVAL, interval);
        write_reg(CFG_MIN_SAMPLES, min_samp);
        write_reg(CFG_WARN_RATE, rate);
        n_settings++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_values();
        for (int i = 0; i < 4; i++) check_reg(t_cfg_reg'(i));
    endtask

    task automatic test_directed();
        // all-zero first snapshot seeds the baseline
        set_link('0, '0);
        send_link(1'b0);
        // suppress with every field at its maximum clears everything
        send_snap(t_snapshot'({1'b1, {7{32'hFFFF_FFFF}}}));
        set_link(32'hFFFF_FF00, t_counter'(100));
        send_link(1'b0);
        bump(100, 7, 0, 0, 0, 0, 0);                 // too soon: state held
        bump(500, 50, 0, 0, 0, 0, 0);                // gap wraps past zero, stall tick one
        bump(600, 5000, 0, 0, 0, 0, 0);
        bump(600, 5000, 0, 0, 0, 0, 0);              // third stall sample raises the alarm
        bump(600, 0, 30, 10, 3, 20000, 0);           // frames resume, none parsed, middle band
        bump(600, 100, 10, 40, 0, 0, 0);             // failures reach frames: high band
        bump(600, 100, 10, 0, 0, 0, 0);              // third unparsed sample
        bump(600, 100, 10, 0, 0, 0, 40);             // parses resume
        link_cnt[CNT_FRAMES] -= 5;
        bump(600, 1, 0, 0, 0, 0, 0);                 // counter went down: windows cleared
        bump(499, 1000, 0, 0, 0, 0, 0);              // one short of the interval
        bump(1, 1000, 0, 0, 0, 0, 0);                // exactly the interval
        set_link(32'hFFFF_FFFF, 32'hFFFF_FFFF);       // huge deltas, top buckets
        send_link(1'b0);
        set_link(link_time + 700, '0);                // everything goes down
        send_link(1'b0);
        set_link('0, '0);
        send_link(1'b1);
        bump(0, 10, 0, 0, 0, 0, 0);                  // first after suppress, zero gap
    endtask

    task automatic test_config_extremes();
        // zero sustain acts as one, zero rate warns on any failure
        set_config(0, 0, 0, 0);
        set_link($urandom, t_counter'(1000));
        send_link(1'b0);
        bump(0, 10, 0, 1, 0, 0, 0);
        bump(0, 0, 100, 0, 0, 0, 100);
        // widest interval and sample floor, rate above one hundred never warns
        set_config(255, 65535, 65535, 127);
        set_link($urandom, '0);
        send_link(1'b0);
        bump(65534, 10, 0, 5, 0, 0, 0);
        bump(1, 10, 0, 5, 0, 0, 0);
        bump(65535, 0, 10, 20, 1, 1, 0);
        // full rate: warns only with failures and no frames
        set_config(255, 0, 1, 100);
        bump(0, 0, 0, 5, 0, 0, 0);
        bump(0, 0, 1, 0, 0, 0, 1);
        // tick counter runs into its ceiling with the longest sustain
        set_config(255, 0, 20, 1);
        repeat (260) bump(0, 1, 0, 0, 0, 0, 0);
        bump(0, 1, 50, 2, 0, 0, 50);
    endtask

    task automatic test_random_phase(int unsigned tx_pct, int unsigned rx_pct, int unsigned n);
        set_config($urandom_range(1, 6), $urandom_range(0, 1000), $urandom_range(0, 200),
                   $urandom_range(1, 100));
        set_link($urandom, t_counter'($urandom_range(0, 1000)));
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (n) random_step();
    endtask

    // Fill the block against a held receiver, then pause until it drains.
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_left   = LONG_HOLD;
        repeat (40) random_step();
        drain_reports();
        repeat (20) random_step();
    endtask

    initial begin
        snap_ch.valid   = 1'b0;
        snap_ch.payload = '0;
        cfg.sustain_ticks          = SUSTAIN_RESET;
        cfg.min_sample_interval_ms = INTERVAL_RESET;
        cfg.min_checksum_samples   = MIN_SAMP_RESET;
        cfg.warn_rate_percent      = RATE_RESET;
        clear_all();
        set_link('0, '0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_directed();
        test_config_extremes();
        test_random_phase(30, 56, 40);
        test_random_phase(56, 30, 40);
        test_random_phase(0, 0, 40);
        test_backpressure();
        drain_reports();

        $display("Sent %0d snapshots and checked %0d reports over %0d register settings,",
                 n_snaps, n_reports, n_settings);
        $display("with random stalls on both sides and a long receiver hold-off; %0d mismatches",
                 mismatches);
        if (mismatches == 0) begin
            $display("PASS link_health_monitor");
        end else begin
            $display("FAIL link_health_monitor");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/lhm_pkg.sv
hdl/lhm_if.sv
hdl/lhm_fold.sv
hdl/lhm_judge.sv
hdl/link_health_monitor.sv
hdl/lhm_checker.sv
verif/tb_link_health_monitor.sv
